### sv/nssp_pkg.sv
// nssp_pkg: shared types and constants for the nearest seed point search unit
// holds the item mode codes, field widths and the packed seed word
// no dependencies
package nssp_pkg;

  localparam int COORD_BITS = 16;
  localparam int DIST_W     = 33;
  localparam int INDEX_W    = 8;
  localparam int MODE_W     = 2;

  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t dip;
    coord_t strike;
  } seed_t;

endpackage

### sv/nearest_seed_point_search_unit.sv
// a query scans the stored seeds in turn between its transfer and its result:
// one seed read from the seed memory per cycle, then a three-stage distance pipeline
// a load or a clear completes on its transfer; the next item is taken while a result waits
// reset (rst_n low, synchronous) empties the seed set and drops any pending result
// seed memory contents are not cleared by reset, only the fill count is
// depends on nssp_pkg
module nearest_seed_point_search_unit #(
  parameter int MAX_SEEDS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // coord_strike [15:0], coord_dip [31:16]
  input  logic [1:0]  in_tuser,   // mode [1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // nearest_index [7:0], min_distance_sq [40:8], zeros
  output logic [0:0]  out_tuser   // found [0]
);

  localparam int CNT_W = $clog2(MAX_SEEDS + 1);
  localparam int IDX_W = $clog2(MAX_SEEDS);
  localparam int CW    = nssp_pkg::COORD_BITS;
  localparam int DW    = nssp_pkg::DIST_W;
  localparam int NW    = nssp_pkg::INDEX_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] seed_count_r, seed_count_nxt;
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;

  nssp_pkg::seed_t  seed_mem [MAX_SEEDS];
  nssp_pkg::seed_t  rd_data_r;
  nssp_pkg::seed_t  wr_data;
  nssp_pkg::coord_t q_strike_r, q_dip_r;

  logic             in_xfer, out_xfer, seed_full, wr_en, rd_en, scan_end, out_free;
  logic [1:0]       in_mode;

  logic             v1_r, v2_r;
  logic [IDX_W-1:0] idx1_r, idx2_r;
  logic [CW-1:0]    sq_s_mag, sq_d_mag;
  logic [2*CW-1:0]  sq_s_r, sq_d_r;
  logic signed [CW:0] diff_s, diff_d, neg_s, neg_d;
  logic [DW-1:0]    dist_sum;

  logic             have_r;
  logic [DW-1:0]    best_r;
  logic [IDX_W-1:0] best_idx_r;
  logic [IDX_W+NW-1:0] best_idx_ext;

  logic             out_tvalid_r;
  logic [NW-1:0]    out_idx_r;
  logic [DW-1:0]    out_dist_r;
  logic             out_found_r;

  assign in_mode   = in_tuser;
  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid & in_tready;
  assign out_xfer  = out_tvalid_r & out_tready;
  assign out_free  = ~out_tvalid_r | out_tready;
  assign seed_full = (seed_count_r == CNT_W'(MAX_SEEDS));
  assign wr_en     = in_xfer & (in_mode == nssp_pkg::MODE_LOAD) & ~seed_full;
  assign wr_data   = '{dip: in_tdata[31:16], strike: in_tdata[15:0]};
  assign rd_en     = (state_r == ST_SCAN) & (rd_idx_r < seed_count_r);
  assign scan_end  = ~rd_en & ~v1_r & ~v2_r;

  // seed memory: one write port for loads, one registered read port for the scan
  always_ff @(posedge clk) begin
    if (wr_en) begin
      seed_mem[seed_count_r[IDX_W-1:0]] <= wr_data;
    end
    rd_data_r <= seed_mem[rd_idx_r[IDX_W-1:0]];
  end

  always_comb begin
    state_nxt      = state_r;
    seed_count_nxt = seed_count_r;
    rd_idx_nxt     = rd_idx_r;
    unique case (state_r)
      ST_IDLE: begin
        rd_idx_nxt = '0;
        if (in_xfer) begin
          unique case (in_mode)
            nssp_pkg::MODE_LOAD: begin
              if (!seed_full) seed_count_nxt = seed_count_r + CNT_W'(1);
            end
            nssp_pkg::MODE_QUERY: state_nxt = ST_SCAN;
            nssp_pkg::MODE_CLEAR: seed_count_nxt = '0;
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (rd_en) rd_idx_nxt = rd_idx_r + CNT_W'(1);
        if (scan_end) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      seed_count_r <= '0;
      rd_idx_r     <= '0;
    end else begin
      state_r      <= state_nxt;
      seed_count_r <= seed_count_nxt;
      rd_idx_r     <= rd_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && in_mode == nssp_pkg::MODE_QUERY) begin
      q_strike_r <= in_tdata[15:0];
      q_dip_r    <= in_tdata[31:16];
    end
  end

  // stage 2: absolute differences and squares of the seed just read
  assign diff_s   = {q_strike_r[CW-1], q_strike_r} - {rd_data_r.strike[CW-1], rd_data_r.strike};
  assign diff_d   = {q_dip_r[CW-1], q_dip_r} - {rd_data_r.dip[CW-1], rd_data_r.dip};
  assign neg_s    = -diff_s;
  assign neg_d    = -diff_d;
  assign sq_s_mag = diff_s[CW] ? neg_s[CW-1:0] : diff_s[CW-1:0];
  assign sq_d_mag = diff_d[CW] ? neg_d[CW-1:0] : diff_d[CW-1:0];

  // stage 3: sum and running minimum, strictly smaller wins so ties keep the low index
  assign dist_sum = {1'b0, sq_s_r} + {1'b0, sq_d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      have_r <= 1'b0;
    end else begin
      v1_r <= rd_en;
      v2_r <= v1_r;
      if (in_xfer) begin
        have_r <= 1'b0;
      end else if (v2_r && (!have_r || dist_sum < best_r)) begin
        have_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx1_r <= rd_idx_r[IDX_W-1:0];
    idx2_r <= idx1_r;
    sq_s_r <= sq_s_mag * sq_s_mag;
    sq_d_r <= sq_d_mag * sq_d_mag;
    if (v2_r && (!have_r || dist_sum < best_r)) begin
      best_r     <= dist_sum;
      best_idx_r <= idx2_r;
    end
  end

  assign best_idx_ext = {{NW{1'b0}}, best_idx_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_tvalid_r <= 1'b1;
    end else if (out_xfer) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_found_r <= have_r;
      out_idx_r   <= have_r ? best_idx_ext[NW-1:0] : '0;
      out_dist_r  <= have_r ? best_r : '0;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'd0, out_dist_r, out_idx_r};
  assign out_tuser  = out_found_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    seed_count_r <= CNT_W'(MAX_SEEDS))
    else $error("seed count above capacity");

  a_read_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> rd_idx_r < CNT_W'(MAX_SEEDS))
    else $error("seed read beyond memory");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && !out_found_r) |-> (out_dist_r == '0 && out_idx_r == '0))
    else $error("empty set result carries data");

  a_pipe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> (!v1_r && !v2_r))
    else $error("distance pipeline busy after scan end");
`endif

endmodule
